### src/airfoil_thickness_eval_top_defines.svh
// assertion macros for the airfoil thickness evaluator checker
// no dependencies; taken in by the checker file only
`ifndef AIRFOIL_THICKNESS_EVAL_TOP_DEFINES_SVH
`define AIRFOIL_THICKNESS_EVAL_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is held
`define AFTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is held
`define AFTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycles
`define AFTE_ASSERT_NEXT_NORST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/afte_pkg.sv
// shared constants, coefficients and stage types for the airfoil thickness evaluator
// no dependencies; used by every module of the block
package afte_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int CQ        = 30;
  localparam int X_W       = 17;
  localparam int K_W       = 19;
  localparam int Y_W       = 18;

  // root chain widths
  localparam int ROOT_W    = CQ + 1;
  localparam int REM_W     = ROOT_W + 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int RAD_SHIFT = 2 * CQ - FRAC_BITS;
  localparam int XQ_SHIFT  = CQ - FRAC_BITS;

  // multiply-accumulate widths
  localparam int ACC_W     = 32;
  localparam int PROD_W    = 2 * ACC_W;

  // stream widths, whole bytes
  localparam int IN_TDATA_W  = ((X_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((Y_W + 7) / 8) * 8;

  localparam logic [X_W-1:0] X_ONE = X_W'(1) << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (Y_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) <<< (Y_W - 1));

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (CQ - 1);

  // thickness polynomial coefficients, Q.30 rounded to nearest
  localparam logic signed [ACC_W-1:0] COEF_0 = 32'sd318793948;
  localparam logic signed [ACC_W-1:0] COEF_1 = -32'sd135291470;
  localparam logic signed [ACC_W-1:0] COEF_2 = -32'sd377527625;
  localparam logic signed [ACC_W-1:0] COEF_3 = 32'sd305264801;
  localparam logic signed [ACC_W-1:0] COEF_4 = -32'sd108984795;

  // one stage of the square root chain
  typedef struct packed {
    logic             valid;
    logic [X_W-1:0]    x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

  // operands into one multiply-round-add cell
  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] a;
    logic [ROOT_W-1:0]       b;
    logic signed [ACC_W-1:0] addend;
    logic [X_W-1:0]          x;
    logic signed [ACC_W-1:0] aux;
  } mac_in_t;

  // registered result of one multiply-round-add cell
  typedef struct packed {
    logic                    valid;
    logic [X_W-1:0]          x;
    logic signed [ACC_W-1:0] res;
    logic signed [ACC_W-1:0] aux;
  } mac_stage_t;

endpackage

### src/afte_sqrt_cell.sv
// one cell of the pipelined square root: settles one root bit per cell
// depends on afte_pkg for widths and the stage type
module afte_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  afte_pkg::sqrt_stage_t     stage_i,
  input  logic [1:0]                pair_i,
  output afte_pkg::sqrt_stage_t     stage_o
);

  logic [afte_pkg::REM_W+1:0]  cur;
  logic [afte_pkg::REM_W+1:0]  trial;
  logic [afte_pkg::REM_W+1:0]  diff;
  logic                        take;
  logic [afte_pkg::REM_W-1:0]  rem_nxt;
  logic [afte_pkg::ROOT_W-1:0] root_nxt;

  logic                        valid_r;
  logic [afte_pkg::X_W-1:0]    x_r;
  logic [afte_pkg::REM_W-1:0]  rem_r;
  logic [afte_pkg::ROOT_W-1:0] root_r;

  // bring down two radicand bits and try the next root bit
  assign cur   = {stage_i.rem, pair_i};
  assign trial = (afte_pkg::REM_W + 2)'({stage_i.root, 2'b01});
  assign diff  = cur - trial;
  assign take  = (cur >= trial);

  always_comb begin
    if (take) begin
      rem_nxt  = diff[afte_pkg::REM_W-1:0];
      root_nxt = {stage_i.root[afte_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[afte_pkg::REM_W-1:0];
      root_nxt = {stage_i.root[afte_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= stage_i.x;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stage_o = '{valid: valid_r, x: x_r, rem: rem_r, root: root_r};

endmodule

### src/afte_mac_cell.sv
// one multiply-round-add cell: res = addend + round(a * b / 2^30)
// depends on afte_pkg for widths, rounding constant and stage types
module afte_mac_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  afte_pkg::mac_in_t      mac_i,
  output afte_pkg::mac_stage_t   stage_o
);

  logic signed [afte_pkg::ACC_W-1:0]  b_s;
  logic signed [afte_pkg::PROD_W-1:0] prod;
  logic signed [afte_pkg::PROD_W-1:0] rnd;
  logic signed [afte_pkg::PROD_W-1:0] shifted;
  logic signed [afte_pkg::ACC_W-1:0]  res_nxt;

  logic                               valid_r;
  logic [afte_pkg::X_W-1:0]           x_r;
  logic signed [afte_pkg::ACC_W-1:0]  res_r;
  logic signed [afte_pkg::ACC_W-1:0]  aux_r;

  // signed product, round half up, arithmetic shift floors
  assign b_s     = signed'(afte_pkg::ACC_W'(mac_i.b));
  assign prod    = afte_pkg::PROD_W'(mac_i.a) * afte_pkg::PROD_W'(b_s);
  assign rnd     = prod + afte_pkg::RND_HALF;
  assign shifted = rnd >>> afte_pkg::CQ;
  assign res_nxt = mac_i.addend + signed'(shifted[afte_pkg::ACC_W-1:0]);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= mac_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= mac_i.x;
      res_r <= res_nxt;
      aux_r <= mac_i.aux;
    end
  end

  assign stage_o = '{valid: valid_r, x: x_r, res: res_r, aux: aux_r};

endmodule

### src/airfoil_thickness_eval_top.sv
// top level of the four-digit airfoil half-thickness evaluator
// depends on afte_pkg, afte_sqrt_cell and afte_mac_cell
//
//  channel | ports       | payload
//  --------+-------------+------------------------------------------
//  in      | in_t*       | chord_position, unsigned Q1.16
//  out     | out_t*      | half_thickness, signed Q1.16, saturated
//  cfg     | cfg_*       | thickness_scale, unsigned Q3.16
//
// one item per cycle unless a waiting result stalls the chain; 39 register stages:
// entry register, 31 square root cells (one root bit each), six multiply cells
// (root coefficient, four Horner steps, scale) and the output register; the entry
// register loads at the accepting edge, or from the skid when the chain was frozen.
// a waiting result freezes the whole chain; a one-item skid register keeps
// in_tready independent of out_tready. synchronous reset clears the valid
// flags and the scale register; there is no clearing pass.
module airfoil_thickness_eval_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [afte_pkg::IN_TDATA_W-1:0] in_tdata,   // [16:0] chord_position, rest zero
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [afte_pkg::OUT_TDATA_W-1:0] out_tdata, // [17:0] half_thickness, rest zero
  // scale register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afte_pkg::K_W-1:0]        cfg_data
);

  localparam int NMAC = 6;

  logic                         en;
  logic [afte_pkg::X_W-1:0]     in_x;
  logic [afte_pkg::X_W-1:0]     in_x_clamped;

  logic                         skid_valid_r;
  logic [afte_pkg::X_W-1:0]     skid_x_r;
  logic                         entry_valid_r;
  logic [afte_pkg::X_W-1:0]     entry_x_r;
  logic [afte_pkg::K_W-1:0]     k_r;
  logic                         out_valid_r;
  logic [afte_pkg::Y_W-1:0]     out_y_r;
  logic [afte_pkg::Y_W-1:0]     out_y_nxt;

  afte_pkg::sqrt_stage_t        sq [afte_pkg::ROOT_W+1];
  afte_pkg::mac_in_t            mi [NMAC];
  afte_pkg::mac_stage_t         mo [NMAC];
  logic [afte_pkg::ROOT_W-1:0]  xq [NMAC];

  // chain advances unless a finished result is still waiting
  assign en        = !out_valid_r || out_tready;
  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;

  // chord positions beyond one are clamped to one
  assign in_x         = in_tdata[afte_pkg::X_W-1:0];
  assign in_x_clamped = (in_x > afte_pkg::X_ONE) ? afte_pkg::X_ONE : in_x;

  // scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cfg_valid) begin
      k_r <= cfg_data;
    end
  end

  // skid register and entry stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r  <= 1'b0;
      entry_valid_r <= 1'b0;
    end else begin
      if (en) begin
        entry_valid_r <= skid_valid_r || in_tvalid;
        skid_valid_r  <= 1'b0;
      end else if (!skid_valid_r && in_tvalid) begin
        skid_valid_r  <= 1'b1;
      end
    end
  end

  // skid and entry payload
  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_x_r <= in_x_clamped;
    end
    if (en) begin
      entry_x_r <= skid_valid_r ? skid_x_r : in_x_clamped;
    end
  end

  assign sq[0] = '{valid: entry_valid_r, x: entry_x_r, rem: '0, root: '0};

  // square root chain, most significant root bit first
  for (genvar j = 0; j < afte_pkg::ROOT_W; j++) begin : g_sqrt
    localparam int P = afte_pkg::ROOT_W - 1 - j;
    logic [afte_pkg::RAD_W-1:0] rad;

    assign rad = afte_pkg::RAD_W'({sq[j].x, {afte_pkg::RAD_SHIFT{1'b0}}});

    afte_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (sq[j]),
      .pair_i  (rad[2*P+1 -: 2]),
      .stage_o (sq[j+1])
    );
  end

  // chord position in Q.30 at each multiply cell
  assign xq[0] = afte_pkg::ROOT_W'({sq[afte_pkg::ROOT_W].x, {afte_pkg::XQ_SHIFT{1'b0}}});
  for (genvar m = 1; m < NMAC; m++) begin : g_xq
    assign xq[m] = afte_pkg::ROOT_W'({mo[m-1].x, {afte_pkg::XQ_SHIFT{1'b0}}});
  end

  // root term first, then the Horner steps, then the scale
  assign mi[0] = '{valid: sq[afte_pkg::ROOT_W].valid, a: afte_pkg::COEF_0,
                   b: sq[afte_pkg::ROOT_W].root, addend: '0,
                   x: sq[afte_pkg::ROOT_W].x, aux: '0};
  assign mi[1] = '{valid: mo[0].valid, a: afte_pkg::COEF_4, b: xq[1],
                   addend: afte_pkg::COEF_3, x: mo[0].x, aux: mo[0].res};
  assign mi[2] = '{valid: mo[1].valid, a: mo[1].res, b: xq[2],
                   addend: afte_pkg::COEF_2, x: mo[1].x, aux: mo[1].aux};
  assign mi[3] = '{valid: mo[2].valid, a: mo[2].res, b: xq[3],
                   addend: afte_pkg::COEF_1, x: mo[2].x, aux: mo[2].aux};
  // last Horner step adds the root term
  assign mi[4] = '{valid: mo[3].valid, a: mo[3].res, b: xq[4],
                   addend: mo[3].aux, x: mo[3].x, aux: '0};
  assign mi[5] = '{valid: mo[4].valid, a: mo[4].res, b: afte_pkg::ROOT_W'(k_r),
                   addend: '0, x: mo[4].x, aux: '0};

  for (genvar m = 0; m < NMAC; m++) begin : g_mac
    afte_mac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .mac_i   (mi[m]),
      .stage_o (mo[m])
    );
  end

  // saturate to the result field
  always_comb begin
    if (mo[NMAC-1].res > afte_pkg::Y_MAX) begin
      out_y_nxt = afte_pkg::Y_MAX[afte_pkg::Y_W-1:0];
    end else if (mo[NMAC-1].res < afte_pkg::Y_MIN) begin
      out_y_nxt = afte_pkg::Y_MIN[afte_pkg::Y_W-1:0];
    end else begin
      out_y_nxt = mo[NMAC-1].res[afte_pkg::Y_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mo[NMAC-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_y_r <= out_y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = afte_pkg::OUT_TDATA_W'(out_y_r);

endmodule

### src/afte_chk.sv
// port-level checker for the airfoil thickness evaluator, bound to the top level
// depends on afte_pkg and airfoil_thickness_eval_top_defines.svh
`include "airfoil_thickness_eval_top_defines.svh"

module afte_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [afte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // no result right after a reset cycle
  `AFTE_ASSERT_NEXT_NORST(a_out_idle_after_rst, clk, !rst_n, !out_tvalid, "result after reset")

  // a stalled result holds
  `AFTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // input side only backs off when an item went into the skid during an output stall
  `AFTE_ASSERT_SAME(a_skid_fill, clk, rst_n, $fell(in_tready), $past(in_tvalid) && $past(out_tvalid) && !$past(out_tready), "in_tready fell without a stalled item")

  // padding above the result field stays zero
  `AFTE_ASSERT_SAME(a_out_pad, clk, rst_n, out_tvalid, out_tdata[afte_pkg::OUT_TDATA_W-1:afte_pkg::Y_W] == '0, "result padding not zero")

  // scale writes are never refused
  `AFTE_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "scale write refused")

endmodule

bind airfoil_thickness_eval_top afte_chk u_afte_chk (.*);

### dv/testbench.sv
// self-checking testbench for the airfoil half-thickness evaluator
// depends on afte_pkg and airfoil_thickness_eval_top; holds its own bit-exact predictor
// runs directed chord positions, then random ones under several scales and idling mixes
module testbench;

  // per-phase idling mixes
  localparam int MIX_NONE = 0;
  localparam int MIX_SRC  = 1;
  localparam int MIX_SINK = 2;
  localparam int MIX_BOTH = 3;

  localparam int LAT_CYCLES = 39;
  localparam int PHASE_LEN  = 45;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [afte_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [afte_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [afte_pkg::K_W-1:0]         cfg_data = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;

  // expected half-thickness per accepted chord position
  class thickness_board;
    typedef struct {
      logic [afte_pkg::X_W-1:0]        chord;
      logic signed [afte_pkg::Y_W-1:0] thickness;
    } expected_t;

    logic [afte_pkg::K_W-1:0] scale;
    expected_t                expected_thickness[$];

    function new();
      scale = '0;
    endfunction

    // bitwise integer square root
    function longint unsigned chord_root(longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    // drop CQ fraction bits, rounding half up
    function longint round_q30(longint v);
      return (v + (longint'(1) <<< (afte_pkg::CQ - 1))) >>> afte_pkg::CQ;
    endfunction

    function logic signed [afte_pkg::Y_W-1:0] predict_half_thickness(
        logic [afte_pkg::X_W-1:0] x);
      logic [afte_pkg::X_W-1:0] xc;
      longint xq;
      longint root;
      longint h;
      longint t;
      longint y;
      // chord beyond 1.0 is clamped
      xc = (x > afte_pkg::X_ONE) ? afte_pkg::X_ONE : x;
      xq = longint'(xc) <<< (afte_pkg::CQ - afte_pkg::FRAC_BITS);
      root = longint'(chord_root(longint'(unsigned'(xq)) << afte_pkg::CQ));
      // horner chain over the polynomial terms
      h = afte_pkg::COEF_4;
      h = afte_pkg::COEF_3 + round_q30(h * xq);
      h = afte_pkg::COEF_2 + round_q30(h * xq);
      h = afte_pkg::COEF_1 + round_q30(h * xq);
      h = round_q30(h * xq);
      t = round_q30(afte_pkg::COEF_0 * root) + h;
      y = round_q30(longint'(scale) * t);
      if (y > longint'(afte_pkg::Y_MAX)) y = afte_pkg::Y_MAX;
      if (y < longint'(afte_pkg::Y_MIN)) y = afte_pkg::Y_MIN;
      return y[afte_pkg::Y_W-1:0];
    endfunction

    function void note_chord(logic [afte_pkg::X_W-1:0] x);
      expected_t e;
      e.chord = x;
      e.thickness = predict_half_thickness(x);
      expected_thickness.push_back(e);
    endfunction

    function bit check_thickness(logic [afte_pkg::OUT_TDATA_W-1:0] word,
                                 output string why);
      expected_t e;
      logic signed [afte_pkg::Y_W-1:0] got;
      got = word[afte_pkg::Y_W-1:0];
      if (expected_thickness.size() == 0) begin
        why = $sformatf("half_thickness %0d with no item outstanding", got);
        return 1'b0;
      end
      e = expected_thickness.pop_front();
      if (got !== e.thickness) begin
        why = $sformatf("chord %0d scale %0d: half_thickness %0d, expected %0d",
                        e.chord, scale, got, e.thickness);
        return 1'b0;
      end
      if (word[afte_pkg::OUT_TDATA_W-1:afte_pkg::Y_W] !== '0) begin
        why = $sformatf("chord %0d: padding bits %0h not zero", e.chord,
                        word[afte_pkg::OUT_TDATA_W-1:afte_pkg::Y_W]);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_thickness.size();
    endfunction
  endclass

  thickness_board board = new();

  airfoil_thickness_eval_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  task report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      if (!board.check_thickness(out_tdata, why)) report_mismatch(why);
    end
  end

  // send one item; called and returns at a falling edge
  task send_chord(input logic [afte_pkg::X_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= afte_pkg::IN_TDATA_W'(x);
    do @(posedge clk); while (!in_tready);
    board.note_chord(x);
    @(negedge clk);
  endtask

  // scale write once the chain has drained
  task write_scale(input logic [afte_pkg::K_W-1:0] k);
    while (board.pending() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    board.scale = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_mix(input int mix);
    case (mix)
      MIX_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      MIX_SRC:  begin src_idle_pct = 77; sink_stall_pct = 0;  end
      MIX_SINK: begin src_idle_pct = 0;  sink_stall_pct = 77; end
      default:  begin src_idle_pct = 12; sink_stall_pct = 12; end
    endcase
  endtask

  // mostly in range, some beyond 1.0 to hit the clamp and the top bits
  function logic [afte_pkg::X_W-1:0] random_chord();
    if ($urandom_range(7) == 0) return afte_pkg::X_W'($urandom_range(131071, 65537));
    return afte_pkg::X_W'($urandom_range(65536, 0));
  endfunction

  logic [afte_pkg::X_W-1:0] directed_chords[] = '{
    17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd100, 17'd256, 17'd655, 17'd1000,
    17'd16384, 17'd19661, 17'd32768, 17'h0AAAA, 17'd64880, 17'd65535,
    17'd65536, 17'd65537, 17'd98304, 17'h15555, 17'd131071
  };

  logic [afte_pkg::K_W-1:0] phase_scales[] = '{
    19'd524287, 19'd0, 19'd1, 19'd327680, 19'h40000, 19'h3FFFF,
    19'd6554, 19'd0, 19'd524287
  };

  // watchdog
  initial begin
    #(8 * 400000);
    $display("FAIL");
    $finish;
  end

  // main sequence
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sweep at the reset scale, then the usual 5 x 12 percent
    set_mix(MIX_NONE);
    foreach (directed_chords[i]) send_chord(directed_chords[i]);
    in_tvalid <= 1'b0;
    write_scale(19'd39322);
    foreach (directed_chords[i]) send_chord(directed_chords[i]);
    in_tvalid <= 1'b0;

    // random phases over several scales and idling mixes
    foreach (phase_scales[p]) begin
      if (p == 7) write_scale(afte_pkg::K_W'($urandom_range(524287, 0)));
      else write_scale(phase_scales[p]);
      set_mix(p % 4);
      repeat (PHASE_LEN) send_chord(random_chord());
      in_tvalid <= 1'b0;
    end

    // drain
    while (board.pending() != 0) @(negedge clk);
    repeat (LAT_CYCLES + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
